/* design/ring_slot_session_guard_assert.svh */
// assertion macros for the ring slot session guard
`ifndef RING_SLOT_SESSION_GUARD_ASSERT_SVH
`define RING_SLOT_SESSION_GUARD_ASSERT_SVH

// same-cycle implication
`define RSSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rssg_pkg.sv */
`default_nettype none
package rssg_pkg;

	localparam int POS_W  = 64;
	localparam int SID_W  = 32;
	localparam int SLOT_W = 16;
	localparam int OFF_W  = 48;
	localparam int CNT_W  = 3;

	// actions
	localparam logic [2:0] ACT_BEGIN  = 3'd0;
	localparam logic [2:0] ACT_WRITE  = 3'd1;
	localparam logic [2:0] ACT_READ   = 3'd2;
	localparam logic [2:0] ACT_FLUSH  = 3'd3;
	localparam logic [2:0] ACT_FINISH = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_CONCURRENT  = 3'd1;
	localparam logic [2:0] ST_BAD_SESSION = 3'd2;
	localparam logic [2:0] ST_BAD_POS     = 3'd3;
	localparam logic [2:0] ST_BAD_COMP    = 3'd4;

	// register indexes
	localparam logic [2:0] REG_SLOT_COUNT  = 3'd0;
	localparam logic [2:0] REG_READ_WIN    = 3'd1;
	localparam logic [2:0] REG_WRITE_WIN   = 3'd2;
	localparam logic [2:0] REG_META_SIZE   = 3'd3;
	localparam logic [2:0] REG_COMP_COUNT  = 3'd4;
	localparam logic [2:0] REG_COMP_SIZES  = 3'd5;

	typedef struct packed {
		logic              start;
		logic [POS_W-1:0]  dividend;
		logic [SLOT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] rem;
	} div_res_t;

	function automatic logic [15:0] comp_size(input logic [63:0] sizes, input logic [1:0] c);
		comp_size = sizes[16*c +: 16];
	endfunction

endpackage
`default_nettype wire

/* design/rssg_divider.sv */
`default_nettype none
module rssg_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rssg_pkg::div_req_t req,
	output rssg_pkg::div_res_t     res
);

	localparam int CW = $clog2(rssg_pkg::POS_W);

	logic                        run_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [rssg_pkg::POS_W-1:0]  dvd_q;
	logic [rssg_pkg::SLOT_W-1:0] dsr_q;
	logic [rssg_pkg::SLOT_W-1:0] rem_q;
	logic [rssg_pkg::SLOT_W:0]   shifted;
	logic [rssg_pkg::SLOT_W:0]   diff;
	logic                        fits;

	// one restoring step per cycle
	assign shifted = {rem_q, dvd_q[rssg_pkg::POS_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(rssg_pkg::POS_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[rssg_pkg::POS_W-2:0], 1'b0};
			rem_q <= fits ? diff[rssg_pkg::SLOT_W-1:0] : shifted[rssg_pkg::SLOT_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule
`default_nettype wire

/* design/rssg_layout.sv */
`default_nettype none
module rssg_layout #(
	parameter int MAX_COMPONENTS = 4,
	parameter int PAGE_SHIFT     = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rssg_pkg::SLOT_W-1:0] num_slots,
	input  wire logic [31:0]                 meta_len,
	input  wire logic [rssg_pkg::CNT_W-1:0]  num_comps,
	input  wire logic [63:0]                 comp_lens,
	input  wire logic [1:0]                  sel,
	output logic                             busy,
	output logic [rssg_pkg::OFF_W-1:0]       base
);

	localparam int CIDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam logic [rssg_pkg::OFF_W-1:0] PAGE = rssg_pkg::OFF_W'(1) << PAGE_SHIFT;

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_MUL  = 3'b010,
		L_ADD  = 3'b100
	} lay_state_t;

	lay_state_t                   state_q;
	logic [CIDX_W-1:0]            idx_q;
	logic [rssg_pkg::OFF_W-1:0]   total_q;
	logic [31:0]                  prod_q;
	logic [rssg_pkg::OFF_W-1:0]   base_q [MAX_COMPONENTS];

	function automatic logic [rssg_pkg::OFF_W-1:0] page_round(
		input logic [rssg_pkg::OFF_W-1:0] v);
		page_round = (v + (PAGE - 1'b1)) & ~(PAGE - 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						state_q <= L_MUL;
					end
				end
				L_MUL: state_q <= L_ADD;
				L_ADD: begin
					if (idx_q == CIDX_W'(MAX_COMPONENTS - 1)) begin
						state_q <= L_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= L_MUL;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				if (start) begin
					total_q <= page_round(PAGE + rssg_pkg::OFF_W'(meta_len));
				end
			end
			L_MUL: begin
				prod_q <= rssg_pkg::comp_size(comp_lens, 2'(idx_q)) * num_slots;
				base_q[idx_q] <= (rssg_pkg::CNT_W'(idx_q) < num_comps) ? total_q : '0;
			end
			L_ADD: total_q <= page_round(total_q + rssg_pkg::OFF_W'(prod_q));
			default: ;
		endcase
	end

	assign busy = state_q != L_IDLE;
	assign base = base_q[sel[CIDX_W-1:0]];

endmodule
`default_nettype wire

/* design/ring_slot_session_guard.sv */
// ring slot session guard, one word at a time
// begin, flush, finish and rejected accesses go from the check state straight to done
// granted accesses pass through the modulo, multiply and add states before done
// a new word is not taken until the last is done; granted accesses wait on the bit-serial position modulo slot count
// reset: owner cleared, ticket 1, write count 0; the layout pass then holds busy until it completes
// results cannot be stalled: done is high for exactly one cycle
`default_nettype none
module ring_slot_session_guard #(
	parameter int MAX_COMPONENTS = 4,
	parameter int PAGE_SHIFT     = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [2:0]                  action,
	input  wire logic [rssg_pkg::SID_W-1:0]  session_id,
	input  wire logic [rssg_pkg::POS_W-1:0]  position,
	input  wire logic [1:0]                  component_index,
	output logic                             done,
	output logic [2:0]                       status,
	output logic [rssg_pkg::SID_W-1:0]       granted_session,
	output logic [rssg_pkg::SLOT_W-1:0]      slot_index,
	output logic [rssg_pkg::OFF_W-1:0]       byte_offset,
	output logic [15:0]                      byte_length,
	output logic [rssg_pkg::POS_W-1:0]       oldest_position,
	output logic [rssg_pkg::POS_W-1:0]       write_position,
	output logic [rssg_pkg::POS_W-1:0]       last_writable,
	output logic                             active,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [63:0]                 cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_DIV   = 6'b000100,
		S_MUL   = 6'b001000,
		S_ADD   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] num_slots_q;
	logic [15:0] read_window_q;
	logic [15:0] write_window_q;
	logic [31:0] meta_len_q;
	logic [2:0]  num_comps_q;
	logic [63:0] comp_lens_q;
	logic        relayout_q;

	// ring state
	logic [rssg_pkg::SID_W-1:0] owner_q;
	logic [rssg_pkg::SID_W-1:0] ticket_q;
	logic [rssg_pkg::POS_W-1:0] wcount_q;

	// current word
	logic [2:0]                 action_q;
	logic [rssg_pkg::SID_W-1:0] sid_q;
	logic [rssg_pkg::POS_W-1:0] pos_q;
	logic [1:0]                 comp_q;

	// result
	logic [2:0]                  status_q;
	logic [rssg_pkg::SID_W-1:0]  granted_q;
	logic [rssg_pkg::SLOT_W-1:0] slot_q;
	logic [rssg_pkg::OFF_W-1:0]  offset_q;
	logic [15:0]                 length_q;
	logic [31:0]                 prod_q;

	logic                        cfg_we;
	logic [15:0]                 cfg_v16;
	logic                        lay_busy;
	logic                        lay_start;
	logic [rssg_pkg::OFF_W-1:0]  lay_base;
	logic [rssg_pkg::POS_W-1:0]  oldest;
	logic [rssg_pkg::POS_W-1:0]  last_wr;
	logic                        owner_ok;
	logic                        comp_bad;
	rssg_pkg::div_req_t          div_req;
	rssg_pkg::div_res_t          div_res;

	assign oldest   = (wcount_q < rssg_pkg::POS_W'(read_window_q)) ? '0
		: wcount_q - rssg_pkg::POS_W'(read_window_q);
	assign last_wr  = wcount_q + rssg_pkg::POS_W'(write_window_q) - 1'b1;
	assign owner_ok = (sid_q != '0) && (sid_q == owner_q);
	assign comp_bad = ({1'b0, comp_q} >= num_comps_q)
		|| ({1'b0, comp_q} >= 3'(MAX_COMPONENTS));

	assign busy      = (state_q != S_IDLE) || lay_busy || relayout_q;
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign cfg_v16   = cfg_data[15:0];
	assign lay_start = relayout_q && !lay_busy && (state_q == S_IDLE);

	assign div_req.start    = (state_q == S_CHECK)
		&& ((action_q == rssg_pkg::ACT_WRITE && owner_ok && pos_q <= last_wr
		&& pos_q >= wcount_q)
		|| (action_q == rssg_pkg::ACT_READ && pos_q >= oldest && pos_q < wcount_q))
		&& !comp_bad;
	assign div_req.dividend = pos_q;
	assign div_req.divisor  = num_slots_q;

	rssg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	rssg_layout #(
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.PAGE_SHIFT     (PAGE_SHIFT)
	) u_layout (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (lay_start),
		.num_slots (num_slots_q),
		.meta_len  (meta_len_q),
		.num_comps (num_comps_q),
		.comp_lens (comp_lens_q),
		.sel       (comp_q),
		.busy      (lay_busy),
		.base      (lay_base)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_slots_q    <= 16'd2;
			read_window_q  <= 16'd1;
			write_window_q <= 16'd1;
			meta_len_q     <= 32'd1;
			num_comps_q    <= 3'd1;
			comp_lens_q    <= 64'd1;
			relayout_q     <= 1'b1;
		end else begin
			if (lay_start) begin
				relayout_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					rssg_pkg::REG_SLOT_COUNT: begin
						if (cfg_v16 >= 16'd2) begin
							num_slots_q <= cfg_v16;
						end
						relayout_q <= 1'b1;
					end
					rssg_pkg::REG_READ_WIN: begin
						if (cfg_v16 >= 16'd1 && cfg_v16 < num_slots_q) begin
							read_window_q <= cfg_v16;
							if (write_window_q < num_slots_q - cfg_v16) begin
								write_window_q <= num_slots_q - cfg_v16;
							end
						end
					end
					rssg_pkg::REG_WRITE_WIN: begin
						if (cfg_v16 >= 16'd1 && cfg_v16 < num_slots_q) begin
							write_window_q <= cfg_v16;
							if (read_window_q < num_slots_q - cfg_v16) begin
								read_window_q <= num_slots_q - cfg_v16;
							end
						end
					end
					rssg_pkg::REG_META_SIZE: begin
						meta_len_q <= cfg_data[31:0];
						relayout_q <= 1'b1;
					end
					rssg_pkg::REG_COMP_COUNT: begin
						if (cfg_data[2:0] >= 3'd1 && cfg_data[2:0] <= 3'(MAX_COMPONENTS)) begin
							num_comps_q <= cfg_data[2:0];
						end
						relayout_q <= 1'b1;
					end
					rssg_pkg::REG_COMP_SIZES: begin
						comp_lens_q <= cfg_data;
						relayout_q  <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// sequencer and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			owner_q  <= '0;
			ticket_q <= 32'd1;
			wcount_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= div_req.start ? S_DIV : S_DONE;
					unique case (action_q)
						rssg_pkg::ACT_BEGIN: begin
							ticket_q <= ticket_q + 1'b1;
							if (owner_q == '0) begin
								owner_q <= ticket_q;
							end
						end
						rssg_pkg::ACT_FLUSH: begin
							if (owner_ok) begin
								wcount_q <= wcount_q + 1'b1;
							end
						end
						rssg_pkg::ACT_FINISH: begin
							if (owner_ok) begin
								owner_q <= '0;
							end
						end
						default: ;
					endcase
				end
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_ADD;
				S_ADD:  state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				action_q <= action;
				sid_q    <= session_id;
				pos_q    <= position;
				comp_q   <= component_index;
			end
			S_CHECK: begin
				status_q  <= rssg_pkg::ST_OK;
				granted_q <= '0;
				slot_q    <= '0;
				offset_q  <= '0;
				length_q  <= '0;
				unique case (action_q)
					rssg_pkg::ACT_BEGIN: begin
						if (owner_q == '0) begin
							granted_q <= ticket_q;
						end else begin
							status_q <= rssg_pkg::ST_CONCURRENT;
						end
					end
					rssg_pkg::ACT_WRITE: begin
						if (!owner_ok) begin
							status_q <= rssg_pkg::ST_BAD_SESSION;
						end else if (pos_q > last_wr || pos_q < wcount_q) begin
							status_q <= rssg_pkg::ST_BAD_POS;
						end else if (comp_bad) begin
							status_q <= rssg_pkg::ST_BAD_COMP;
						end else begin
							length_q <= rssg_pkg::comp_size(comp_lens_q, comp_q);
						end
					end
					rssg_pkg::ACT_READ: begin
						if (pos_q < oldest || pos_q >= wcount_q) begin
							status_q <= rssg_pkg::ST_BAD_POS;
						end else if (comp_bad) begin
							status_q <= rssg_pkg::ST_BAD_COMP;
						end else begin
							length_q <= rssg_pkg::comp_size(comp_lens_q, comp_q);
						end
					end
					rssg_pkg::ACT_FLUSH, rssg_pkg::ACT_FINISH: begin
						if (!owner_ok) begin
							status_q <= rssg_pkg::ST_BAD_SESSION;
						end
					end
					default: ;
				endcase
			end
			S_DIV: begin
				if (div_res.done) begin
					slot_q <= div_res.rem;
				end
			end
			S_MUL: prod_q <= slot_q * length_q;
			S_ADD: offset_q <= lay_base + rssg_pkg::OFF_W'(prod_q);
			default: ;
		endcase
	end

	assign done            = state_q == S_DONE;
	assign status          = status_q;
	assign granted_session = granted_q;
	assign slot_index      = slot_q;
	assign byte_offset     = offset_q;
	assign byte_length     = length_q;
	assign oldest_position = oldest;
	assign write_position  = wcount_q;
	assign last_writable   = last_wr;
	assign active          = owner_q != '0;

`include "ring_slot_session_guard_assert.svh"

	`RSSG_ASSERT_NEXT(a_done_single, done, !done, "done strobe longer than one cycle")
	`RSSG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`RSSG_ASSERT_NOW(a_div_in_div, div_res.done, state_q == S_DIV, "modulo finished outside its state")
	`RSSG_ASSERT_NOW(a_no_cfg_busy, cfg_ready, !lay_busy && state_q == S_IDLE, "config open while busy")

endmodule
`default_nettype wire
